[src/weighted_harmonic_accumulator_core_defines.svh]
// Assertion macros used by the checker file.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef WEIGHTED_HARMONIC_ACCUMULATOR_CORE_DEFINES_SVH
`define WEIGHTED_HARMONIC_ACCUMULATOR_CORE_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define WHA_ASSERT_NEXT(name, cond, expct) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expct)) \
        else $error("wha check failed");

// The consequent must hold in the same cycle as the antecedent.
`define WHA_ASSERT_NOW(name, cond, expct) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expct)) \
        else $error("wha check failed");

`endif

[src/wha_pkg.sv]
// ----------------------------------------------------------------------------
// wha_pkg
// Shared types, constants and tables for the weighted harmonic accumulator.
// ----------------------------------------------------------------------------
package wha_pkg;

    // Weight table geometry.
    localparam int BINS   = 288;
    localparam int BIN_AW = $clog2(BINS);
    localparam int BIN_CW = ((BIN_AW > 9) ? BIN_AW : 9) + 1;

    // Time and sidereal phase constants.
    localparam logic [31:0] EPOCH      = 32'd1104537600;
    localparam logic [63:0] SID_RATE   = 64'd214088264890868;
    localparam logic [31:0] SID_LO     = SID_RATE[31:0];
    localparam logic [31:0] SID_HI     = SID_RATE[63:32];
    localparam logic [31:0] SID_OFFSET = 32'd375775040;

    // Rotation engine constants, gain in Q2.30 on a 34-bit datapath.
    localparam int CORDIC_STEPS = 16;
    localparam int ITER_W       = $clog2(CORDIC_STEPS);
    localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

    // Configuration register reset values.
    localparam logic [31:0] START_RST  = 32'd0;
    localparam logic [31:0] END_RST    = 32'hFFFF_FFFF;
    localparam logic [13:0] ZENITH_RST = 14'd6000;
    localparam logic [63:0] RATE_RST   = 64'd214088000000000;
    localparam logic [31:0] OFFSET_RST = 32'd376804000;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_START  = 3'd0,
        REG_END    = 3'd1,
        REG_ZENITH = 3'd2,
        REG_RATE   = 3'd3,
        REG_OFFSET = 3'd4
    } cfg_reg_t;

    // Request codes of an input item.
    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_EVENT = 2'd1,
        REQ_READ  = 2'd2,
        REQ_CLEAR = 2'd3
    } req_t;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_LOAD,
        OP_CLEAR,
        OP_STOP,
        OP_READ,
        OP_T0,
        OP_T1,
        OP_T2,
        OP_T3,
        OP_T4,
        OP_BIN,
        OP_ARG,
        OP_CORD,
        OP_RND,
        OP_MC,
        OP_MS,
        OP_ACC
    } dp_op_t;

    typedef struct packed {
        dp_op_t            op;
        logic [ITER_W-1:0] iter;
    } dp_cmd_t;

    typedef struct packed {
        req_t req;
        logic stop;
        logic late;
        logic reject;
        logic out_free;
    } dp_status_t;

    // Arctangent of 2^-i in Q2.32 turns.
    function automatic logic signed [33:0] atan_turn(input logic [ITER_W-1:0] i);
        logic signed [33:0] v;
        case (i)
            4'd0:    v = 34'sd536870912;
            4'd1:    v = 34'sd316933406;
            4'd2:    v = 34'sd167458907;
            4'd3:    v = 34'sd85004756;
            4'd4:    v = 34'sd42667331;
            4'd5:    v = 34'sd21354465;
            4'd6:    v = 34'sd10679838;
            4'd7:    v = 34'sd5340245;
            4'd8:    v = 34'sd2670163;
            4'd9:    v = 34'sd1335087;
            4'd10:   v = 34'sd667544;
            4'd11:   v = 34'sd333772;
            4'd12:   v = 34'sd166886;
            4'd13:   v = 34'sd83443;
            4'd14:   v = 34'sd41722;
            4'd15:   v = 34'sd20861;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

endpackage

[src/wha_if.sv]
// ----------------------------------------------------------------------------
// wha_if
// Request and response channel interfaces of the harmonic accumulator.
// ----------------------------------------------------------------------------
interface wha_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] event_time;
    logic [13:0] zenith;
    logic [15:0] ascension;
    logic [8:0]  bin_index;
    logic [31:0] bin_weight;

    modport source (output valid, req_type, event_time, zenith, ascension,
                    bin_index, bin_weight, input ready);
    modport sink   (input valid, req_type, event_time, zenith, ascension,
                    bin_index, bin_weight, output ready);
endinterface

interface wha_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] sum_cos;
    logic signed [63:0] sum_sin;
    logic [63:0]        sum_weight;
    logic [31:0]        event_count;
    logic               stopped;

    modport source (output valid, sum_cos, sum_sin, sum_weight, event_count,
                    stopped, input ready);
    modport sink   (input valid, sum_cos, sum_sin, sum_weight, event_count,
                    stopped, output ready);
endinterface

[src/wha_ram.sv]
// ----------------------------------------------------------------------------
// wha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 288
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Storage write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[src/wha_datapath.sv]
// ----------------------------------------------------------------------------
// wha_datapath
// Registers, shared multiplier, rotation engine, weight table and
// saturating accumulators, driven one operation per cycle by the controller.
// ----------------------------------------------------------------------------
module wha_datapath
    import wha_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    wha_req_if.sink       req,
    wha_rsp_if.source     rsp,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [63:0]   cfg_data,
    input  dp_cmd_t       cmd,
    output dp_status_t    status
);

    // Configuration registers.
    logic [31:0] start_reg;
    logic [31:0] end_reg;
    logic [13:0] zen_max_reg;
    logic [63:0] rate_reg;
    logic [31:0] offset_reg;

    // Latched request.
    req_t        req_reg;
    logic [31:0] time_reg;
    logic [13:0] zen_reg;
    logic [15:0] asc_reg;
    logic [8:0]  idx_reg;
    logic [31:0] wdat_reg;

    // Event working registers.
    logic [63:0]        prod_reg;
    logic [31:0]        tph_reg;
    logic [31:0]        sph_reg;
    logic [BIN_AW-1:0]  bin_reg;
    logic signed [33:0] x_reg, y_reg, z_reg;
    logic               neg_reg;
    logic signed [15:0] c_reg, s_reg;

    // Accumulator state.
    logic signed [63:0] acc_cos_reg, acc_sin_reg;
    logic [63:0]        acc_w_reg;
    logic [31:0]        count_reg;
    logic               stop_reg;

    // Output register.
    logic               out_valid_reg;
    logic signed [63:0] out_cos_reg, out_sin_reg;
    logic [63:0]        out_w_reg;
    logic [31:0]        out_cnt_reg;
    logic               out_stop_reg;

    logic [31:0]        dlo;
    logic               dneg;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_full;
    logic [31:0]        arg;
    logic signed [33:0] z0, z_init, atan_v, dx, dy;
    logic               neg_init;
    logic signed [33:0] xs, ys, xr, yr;
    logic signed [15:0] c_q, s_q;
    logic [64:0]        sum_acc;
    logic signed [63:0] acc_next;
    logic [64:0]        w_sum;
    logic [BIN_CW-1:0]  idx_ext;
    logic               ram_we, ram_re;
    logic [31:0]        w_rd;

    // Status for the controller.
    assign status.req      = req_reg;
    assign status.stop     = stop_reg;
    assign status.late     = time_reg > end_reg;
    assign status.reject   = (time_reg < start_reg) || (zen_reg > zen_max_reg);
    assign status.out_free = !out_valid_reg || rsp.ready;

    // Event time relative to the epoch, low word and sign.
    assign dlo  = time_reg - EPOCH;
    assign dneg = time_reg < EPOCH;

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_T0:
            begin
                mul_a = {1'b0, dlo};
                mul_b = {1'b0, rate_reg[31:0]};
            end
            OP_T1:
            begin
                mul_a = {1'b0, dlo};
                mul_b = {1'b0, rate_reg[63:32]};
            end
            OP_T2:
            begin
                mul_a = {1'b0, dlo};
                mul_b = {1'b0, SID_LO};
            end
            OP_T3:
            begin
                mul_a = {1'b0, dlo};
                mul_b = {1'b0, SID_HI};
            end
            OP_BIN:
            begin
                mul_a = {1'b0, tph_reg};
                mul_b = 33'(BINS);
            end
            OP_MC:
            begin
                mul_a = {1'b0, w_rd};
                mul_b = 33'(c_reg);
            end
            OP_MS:
            begin
                mul_a = {1'b0, w_rd};
                mul_b = 33'(s_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // Angle fold into a quarter turn around zero.
    assign arg = tph_reg + {asc_reg, 16'h0000} - sph_reg;
    assign z0  = 34'(signed'(arg));
    always_comb
    begin
        z_init   = z0;
        neg_init = 1'b0;
        if (z0 > 34'sd1073741824)
        begin
            z_init   = z0 - 34'sd2147483648;
            neg_init = 1'b1;
        end
        else if (z0 < -34'sd1073741824)
        begin
            z_init   = z0 + 34'sd2147483648;
            neg_init = 1'b1;
        end
    end

    // One rotation step.
    assign atan_v = atan_turn(cmd.iter);
    assign dx     = y_reg >>> cmd.iter;
    assign dy     = x_reg >>> cmd.iter;

    // Sign restore, rounding and clamping to Q1.15.
    assign xs = neg_reg ? -x_reg : x_reg;
    assign ys = neg_reg ? -y_reg : y_reg;
    assign xr = (xs + 34'sd16384) >>> 15;
    assign yr = (ys + 34'sd16384) >>> 15;
    always_comb
    begin
        if (xr > 34'sd32767)
            c_q = 16'sh7FFF;
        else if (xr < -34'sd32768)
            c_q = -16'sh8000;
        else
            c_q = xr[15:0];
        if (yr > 34'sd32767)
            s_q = 16'sh7FFF;
        else if (yr < -34'sd32768)
            s_q = -16'sh8000;
        else
            s_q = yr[15:0];
    end

    // Signed saturating add of the last product into the selected sum.
    always_comb
    begin
        if (cmd.op == OP_MS)
            sum_acc = {acc_cos_reg[63], acc_cos_reg} + {prod_reg[63], prod_reg};
        else
            sum_acc = {acc_sin_reg[63], acc_sin_reg} + {prod_reg[63], prod_reg};
        if (sum_acc[64] != sum_acc[63])
            acc_next = sum_acc[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
            acc_next = sum_acc[63:0];
    end

    assign w_sum = {1'b0, acc_w_reg} + 65'(w_rd);

    // Weight table access.
    assign idx_ext = BIN_CW'(idx_reg);
    assign ram_we  = (cmd.op == OP_LOAD) && (idx_ext < BIN_CW'(BINS));
    assign ram_re  = (cmd.op == OP_CORD) && (cmd.iter == '0);

    wha_ram #(
        .WIDTH (32),
        .DEPTH (BINS)
    ) u_weight_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (BIN_AW'(idx_ext)),
        .wdata (wdat_reg),
        .re    (ram_re),
        .raddr (bin_reg),
        .rdata (w_rd)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg   <= START_RST;
            end_reg     <= END_RST;
            zen_max_reg <= ZENITH_RST;
            rate_reg    <= RATE_RST;
            offset_reg  <= OFFSET_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START:  start_reg   <= cfg_data[31:0];
                REG_END:    end_reg     <= cfg_data[31:0];
                REG_ZENITH: zen_max_reg <= cfg_data[13:0];
                REG_RATE:   rate_reg    <= cfg_data;
                REG_OFFSET: offset_reg  <= cfg_data[31:0];
                default:    ;
            endcase
        end
    end

    // Accumulators, stop flag and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_cos_reg   <= '0;
            acc_sin_reg   <= '0;
            acc_w_reg     <= '0;
            count_reg     <= '0;
            stop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // A new result is only offered once the previous one has left.
            if (cmd.op == OP_READ)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
            case (cmd.op)
                OP_CLEAR:
                begin
                    acc_cos_reg <= '0;
                    acc_sin_reg <= '0;
                    acc_w_reg   <= '0;
                    count_reg   <= '0;
                    stop_reg    <= 1'b0;
                end
                OP_STOP:
                    stop_reg <= 1'b1;
                OP_MS:
                    acc_cos_reg <= acc_next;
                OP_ACC:
                begin
                    acc_sin_reg <= acc_next;
                    acc_w_reg   <= w_sum[64] ? {64{1'b1}} : w_sum[63:0];
                    if (count_reg != {32{1'b1}})
                        count_reg <= count_reg + 32'd1;
                end
                default: ;
            endcase
        end
    end

    // Payload registers of the request, the event pipeline and the result.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_full[63:0];
        case (cmd.op)
            OP_LATCH:
            begin
                req_reg  <= req_t'(req.req_type);
                time_reg <= req.event_time;
                zen_reg  <= req.zenith;
                asc_reg  <= req.ascension;
                idx_reg  <= req.bin_index;
                wdat_reg <= req.bin_weight;
            end
            OP_READ:
            begin
                out_cos_reg  <= acc_cos_reg;
                out_sin_reg  <= acc_sin_reg;
                out_w_reg    <= acc_w_reg;
                out_cnt_reg  <= count_reg;
                out_stop_reg <= stop_reg;
            end
            OP_T1:
                tph_reg <= prod_reg[63:32] + offset_reg - (dneg ? rate_reg[31:0] : 32'd0);
            OP_T2:
                tph_reg <= tph_reg + prod_reg[31:0];
            OP_T3:
                sph_reg <= prod_reg[63:32] + SID_OFFSET - (dneg ? SID_LO : 32'd0);
            OP_T4:
                sph_reg <= sph_reg + prod_reg[31:0];
            OP_ARG:
            begin
                bin_reg <= prod_reg[32 +: BIN_AW];
                x_reg   <= CORDIC_K;
                y_reg   <= '0;
                z_reg   <= z_init;
                neg_reg <= neg_init;
            end
            OP_CORD:
            begin
                if (!z_reg[33])
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - atan_v;
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + atan_v;
                end
            end
            OP_RND:
            begin
                c_reg <= c_q;
                s_reg <= s_q;
            end
            default: ;
        endcase
    end

    // Response channel.
    assign rsp.valid       = out_valid_reg;
    assign rsp.sum_cos     = out_cos_reg;
    assign rsp.sum_sin     = out_sin_reg;
    assign rsp.sum_weight  = out_w_reg;
    assign rsp.event_count = out_cnt_reg;
    assign rsp.stopped     = out_stop_reg;

endmodule

[src/wha_ctrl.sv]
// ----------------------------------------------------------------------------
// wha_ctrl
// Controller state machine: accepts one item, steps the datapath through
// the operations the request needs, and returns to idle.
// ----------------------------------------------------------------------------
module wha_ctrl
    import wha_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    wha_req_if.sink    req,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_T1,
        S_T2,
        S_T3,
        S_T4,
        S_BIN,
        S_ARG,
        S_CORD,
        S_RND,
        S_MC,
        S_MS,
        S_ACC
    } state_t;

    state_t            state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;

    assign req.ready = (state_reg == S_IDLE);

    // Next state and issued operation.
    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        cmd.iter   = iter_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                case (status.req)
                    REQ_LOAD:  cmd.op = OP_LOAD;
                    REQ_CLEAR: cmd.op = OP_CLEAR;
                    REQ_READ:  state_next = S_READ;
                    REQ_EVENT:
                    begin
                        if (status.stop)
                            cmd.op = OP_NONE;
                        else if (status.late)
                            cmd.op = OP_STOP;
                        else if (!status.reject)
                        begin
                            cmd.op     = OP_T0;
                            state_next = S_T1;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_READ:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_READ;
                    state_next = S_IDLE;
                end
            end
            S_T1:
            begin
                cmd.op     = OP_T1;
                state_next = S_T2;
            end
            S_T2:
            begin
                cmd.op     = OP_T2;
                state_next = S_T3;
            end
            S_T3:
            begin
                cmd.op     = OP_T3;
                state_next = S_T4;
            end
            S_T4:
            begin
                cmd.op     = OP_T4;
                state_next = S_BIN;
            end
            S_BIN:
            begin
                cmd.op     = OP_BIN;
                state_next = S_ARG;
            end
            S_ARG:
            begin
                cmd.op     = OP_ARG;
                iter_next  = '0;
                state_next = S_CORD;
            end
            S_CORD:
            begin
                cmd.op    = OP_CORD;
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(CORDIC_STEPS - 1))
                    state_next = S_RND;
            end
            S_RND:
            begin
                cmd.op     = OP_RND;
                state_next = S_MC;
            end
            S_MC:
            begin
                cmd.op     = OP_MC;
                state_next = S_MS;
            end
            S_MS:
            begin
                cmd.op     = OP_MS;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.op     = OP_ACC;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

endmodule

[src/weighted_harmonic_accumulator_core.sv]
// An event runs through S_DECODE, S_T1 to S_T4, S_BIN, S_ARG, S_CORD, S_RND,
// S_MC, S_MS and S_ACC to its updated sums; load and clear act in S_DECODE, a
// read in S_READ once the output is free. One item at a time: an event uses
// 16 rotation steps on one engine and seven passes of one 33x33 multiplier.
// Reset clears control, accumulators, stop flag and configuration to defaults;
// the weight table is not cleared and holds nothing until loaded.
// ----------------------------------------------------------------------------
// weighted_harmonic_accumulator_core
// First-harmonic accumulator of weighted event records: controller and
// datapath joined by a command and status pair.
// ----------------------------------------------------------------------------
module weighted_harmonic_accumulator_core
    import wha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    wha_req_if.sink     req,
    wha_rsp_if.source   rsp,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer.
    wha_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .status (status),
        .cmd    (cmd)
    );

    // Arithmetic and storage.
    wha_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

[src/wha_checker.sv]
// ----------------------------------------------------------------------------
// wha_checker
// Port-level checks of the harmonic accumulator, bound to the top level.
// ----------------------------------------------------------------------------
`include "weighted_harmonic_accumulator_core_defines.svh"

module wha_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);

    // The block works on one item at a time, so it is busy right after one.
    `WHA_ASSERT_NEXT(a_busy_after_item, in_valid && in_ready, !in_ready)

    // A waiting result stays offered.
    `WHA_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid)

    // A new result only appears while a read is being served.
    `WHA_ASSERT_NOW(a_result_from_read, $rose(out_valid), !$past(in_ready))

endmodule

bind weighted_harmonic_accumulator_core wha_checker u_wha_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready)
);
